/* rtl/core/mau_pkg.sv */
`timescale 1ns / 1ps
package mau_pkg;
  localparam logic [2:0] FN_RED = 3'd0;
  localparam logic [2:0] FN_ADD = 3'd1;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_NEG = 3'd3;
  localparam logic [2:0] FN_MUL = 3'd4;
  localparam logic [2:0] FN_POW = 3'd5;
  localparam logic [2:0] FN_INV = 3'd6;
  localparam logic [2:0] FN_DIV = 3'd7;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_NOINV = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_REDR  = 4'd2;
  localparam logic [3:0] OP_SIMP  = 4'd3;
  localparam logic [3:0] OP_MULAB = 4'd4;
  localparam logic [3:0] OP_PSTEP = 4'd5;
  localparam logic [3:0] OP_SQR   = 4'd6;
  localparam logic [3:0] OP_IINIT = 4'd7;
  localparam logic [3:0] OP_ISTEP = 4'd8;
  localparam logic [3:0] OP_IFIN  = 4'd9;
  localparam logic [3:0] OP_DMUL  = 4'd10;

  typedef struct packed {
    logic [3:0] op;
  } mau_cmd_t;

  typedef struct packed {
    logic div_done;
    logic exp_zero;
    logic exp_bit;
    logic t_zero;
    logic inv_ok;
  } mau_sts_t;
endpackage

/* rtl/core/modular_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Sequencing: a range error goes straight to done; add/sub/neg go through the simplify state;
// reduce and mul use the bit-serial reducer; inv and div run extended Euclid, each step a
// division in the same reducer; pow squares and multiplies per exponent bit through that
// reducer, and takes an inverse at the end for a negative exponent.
// Throughput: one request at a time, the next accepted the cycle after out_valid, which
// lasts one cycle and cannot be stalled. rst_n (sync, active low) idles and resets modulus.
module modular_arithmetic_unit #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic [MOD_BITS-1:0] in_operand_a,
  input  logic [MOD_BITS-1:0] in_operand_b,
  input  logic signed [63:0]  in_exponent,
  input  logic signed [63:0]  in_raw_value,
  input  logic                cfg_we,
  input  logic [MOD_BITS-1:0] cfg_wdata,
  output logic                out_valid,
  output logic [MOD_BITS-1:0] out_result,
  output logic [1:0]          out_error
);
  import mau_pkg::*;
  logic [MOD_BITS-1:0] mod_r;
  mau_cmd_t cmd;
  mau_sts_t sts;
  logic [1:0] err;

  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= MOD_BITS'(64'h7FFF_FFFF);
    else if (cfg_we) mod_r <= cfg_wdata;
  end

  mau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .func_i(in_func),
    .neg_exp_i(in_exponent[63]), .sts_i(sts), .err_i(err), .cmd_o(cmd),
    .busy(busy), .done_o(out_valid)
  );

  mau_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .func_i(in_func), .a_i(in_operand_a), .b_i(in_operand_b),
    .exp_i(in_exponent), .raw_i(in_raw_value), .mod_i(mod_r), .cmd_i(cmd),
    .sts_o(sts), .res_o(out_result), .err_o(err)
  );
  assign out_error = err;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("valid without busy");
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_err_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != ERR_OK) |-> out_result == '0) else $error("nonzero on error");
endmodule

/* rtl/core/mau_datapath.sv */
`timescale 1ns / 1ps
module mau_datapath #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          func_i,
  input  logic [MOD_BITS-1:0] a_i,
  input  logic [MOD_BITS-1:0] b_i,
  input  logic [63:0]         exp_i,
  input  logic [63:0]         raw_i,
  input  logic [MOD_BITS-1:0] mod_i,
  input  mau_pkg::mau_cmd_t   cmd_i,
  output mau_pkg::mau_sts_t   sts_o,
  output logic [MOD_BITS-1:0] res_o,
  output logic [1:0]          err_o
);
  import mau_pkg::*;
  localparam int W = MOD_BITS;
  localparam int PW = 2 * MOD_BITS;
  localparam int SW = MOD_BITS + 2;
  localparam logic [1:0] DST_RES  = 2'd0;
  localparam logic [1:0] DST_ACC  = 2'd1;
  localparam logic [1:0] DST_BASE = 2'd2;
  localparam logic [1:0] DST_EUC  = 2'd3;

  logic [2:0]   func_r;
  logic [W-1:0] m_r, a_r, b_r, base_r, acc_r, res_r, tmp_r;
  logic [63:0]  e_r, raw_r;
  logic         rneg_r;
  logic [1:0]   err_r;
  // shared restoring divider: x_r shifts the dividend out and the quotient in
  logic [63:0]  x_r;
  logic [W-1:0] d_r;
  logic [W:0]   rem_r;
  logic [6:0]   cnt_r;
  logic         busy_r;
  logic [1:0]   dst_r;
  // extended Euclid
  logic [W-1:0] s_r, t_r;
  logic signed [SW-1:0] c0_r, c1_r;

  logic [W-1:0]  m_eff;
  logic          rng_bad;
  logic [W:0]    rsh;
  logic [W:0]    rsub;
  logic          rge;
  logic [PW-1:0] prod;
  logic [W-1:0]  mula, mulb;
  logic [W:0]    sum_ab;
  logic signed [SW+W:0] cq;
  logic [SW:0]   cfix;
  logic [W-1:0]  inv_w, inv_v;
  logic          inv_ok;
  logic          go;
  logic [63:0]   x_ld;
  logic [W-1:0]  d_ld;
  logic [6:0]    cnt_ld;
  logic [1:0]    dst_ld;

  assign m_eff = (mod_i == '0) ? W'(1) : mod_i;
  assign rng_bad = (func_i != FN_RED && a_i >= m_eff) ||
                   ((func_i == FN_ADD || func_i == FN_SUB || func_i == FN_MUL ||
                     func_i == FN_DIV) && b_i >= m_eff);
  assign rsh  = {rem_r[W-1:0], x_r[63]};
  assign rge  = rsh >= {1'b0, d_r};
  assign rsub = rge ? rsh - {1'b0, d_r} : rsh;
  assign sum_ab = {1'b0, a_r} + {1'b0, b_r};
  assign cq = c0_r - c1_r * $signed({1'b0, x_r[W-1:0]});
  assign cfix = (c0_r < 0) ? (SW+1)'(c0_r) + (SW+1)'(m_r) : (SW+1)'(c0_r);
  assign inv_w = W'(cfix);
  assign inv_v = (inv_w == m_r) ? '0 : inv_w;
  assign inv_ok = (s_r == W'(1)) || (m_r == W'(1));

  always_comb begin
    mula = acc_r;
    mulb = base_r;
    case (cmd_i.op)
      OP_MULAB: begin mula = a_r;    mulb = b_r;    end
      OP_SQR:   begin mula = base_r; mulb = base_r; end
      OP_DMUL:  begin mula = a_r;    mulb = tmp_r;  end
      default:  begin mula = acc_r;  mulb = base_r; end
    endcase
  end
  assign prod = PW'(mula) * PW'(mulb);

  always_comb begin
    go = 1'b1;
    x_ld = 64'(prod) << (64 - PW);
    d_ld = m_r;
    cnt_ld = 7'(PW);
    dst_ld = DST_RES;
    case (cmd_i.op)
      OP_REDR: begin
        x_ld = raw_r;
        cnt_ld = 7'd64;
      end
      OP_MULAB, OP_DMUL: dst_ld = DST_RES;
      OP_PSTEP: dst_ld = DST_ACC;
      OP_SQR: dst_ld = DST_BASE;
      OP_ISTEP: begin
        // quotient of s by t
        x_ld = 64'(s_r) << (64 - W);
        d_ld = t_r;
        cnt_ld = 7'(W);
        dst_ld = DST_EUC;
      end
      default: go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      x_r <= x_ld; d_r <= d_ld; rem_r <= '0; cnt_r <= cnt_ld; dst_r <= dst_ld;
      busy_r <= 1'b1;
      if (cmd_i.op == OP_SQR) e_r <= e_r >> 1;
    end else if (busy_r) begin
      if (cnt_r != 7'd0) begin
        rem_r <= rsub; x_r <= {x_r[62:0], rge}; cnt_r <= cnt_r - 7'd1;
      end else begin
        busy_r <= 1'b0;
        case (dst_r)
          DST_RES: res_r <= rem_r[W-1:0];
          DST_ACC: acc_r <= rem_r[W-1:0];
          DST_BASE: base_r <= rem_r[W-1:0];
          default: begin
            s_r <= t_r; t_r <= rem_r[W-1:0];
            c0_r <= c1_r; c1_r <= SW'(cq);
          end
        endcase
      end
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          func_r <= func_i; a_r <= a_i; b_r <= b_i; m_r <= m_eff;
          e_r    <= exp_i[63] ? 64'd0 - exp_i : exp_i;
          rneg_r <= raw_i[63];
          raw_r  <= raw_i[63] ? 64'd0 - raw_i : raw_i;
          err_r  <= rng_bad ? ERR_RANGE : ERR_OK;
          base_r <= a_i; acc_r <= (m_eff == W'(1)) ? '0 : W'(1);
          res_r  <= '0;
        end
        OP_SIMP: begin
          case (func_r)
            FN_RED: res_r <= (rneg_r && res_r != '0) ? m_r - res_r : res_r;
            FN_ADD: res_r <= (sum_ab >= {1'b0, m_r}) ? W'(sum_ab - {1'b0, m_r})
                                                    : W'(sum_ab);
            FN_SUB: res_r <= (a_r >= b_r) ? a_r - b_r : a_r + m_r - b_r;
            FN_NEG: res_r <= (a_r == '0) ? '0 : m_r - a_r;
            FN_POW: res_r <= acc_r;
            default: res_r <= res_r;
          endcase
        end
        OP_IINIT: begin
          s_r <= m_r;
          t_r <= (func_r == FN_INV) ? a_r : (func_r == FN_DIV) ? b_r : acc_r;
          c0_r <= '0; c1_r <= SW'(1);
        end
        OP_IFIN: begin
          if (!inv_ok) begin
            err_r <= ERR_NOINV;
          end
          tmp_r <= inv_v;
          res_r <= inv_v;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.div_done = busy_r && cnt_r == 7'd0;
  assign sts_o.exp_zero = (e_r == 64'd0);
  assign sts_o.exp_bit  = e_r[0];
  assign sts_o.t_zero   = (t_r == '0);
  assign sts_o.inv_ok   = inv_ok;
  assign res_o = (err_r != ERR_OK) ? '0 : res_r;
  assign err_o = err_r;
endmodule

/* rtl/core/mau_ctrl.sv */
`timescale 1ns / 1ps
module mau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        func_i,
  input  logic              neg_exp_i,
  input  mau_pkg::mau_sts_t sts_i,
  input  logic [1:0]        err_i,
  output mau_pkg::mau_cmd_t cmd_o,
  output logic              busy,
  output logic              done_o
);
  import mau_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_WAIT = 4'd2, S_SIMP = 4'd3,
    S_PLOOP = 4'd4, S_PSQR = 4'd5, S_IINIT = 4'd6, S_ISTEP = 4'd7, S_IFIN = 4'd8,
    S_DMUL = 4'd9, S_DONE = 4'd10;
  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  logic [2:0] func_r;
  logic       neg_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    cmd_o.op = OP_NONE;
    case (state_r)
      S_IDLE: if (start) begin cmd_o.op = OP_LOAD; state_nxt = S_CHK; end
      S_CHK: begin
        if (err_i != ERR_OK) state_nxt = S_DONE;
        else begin
          case (func_r)
            FN_RED: begin cmd_o.op = OP_REDR; ret_nxt = S_SIMP; state_nxt = S_WAIT; end
            FN_MUL: begin cmd_o.op = OP_MULAB; ret_nxt = S_DONE; state_nxt = S_WAIT; end
            FN_POW: state_nxt = S_PLOOP;
            FN_INV, FN_DIV: state_nxt = S_IINIT;
            default: state_nxt = S_SIMP;
          endcase
        end
      end
      S_WAIT: if (sts_i.div_done) state_nxt = ret_r;
      S_SIMP: begin cmd_o.op = OP_SIMP; state_nxt = S_DONE; end
      S_PLOOP: begin
        if (sts_i.exp_zero) state_nxt = neg_r ? S_IINIT : S_SIMP;
        else if (sts_i.exp_bit) begin
          cmd_o.op = OP_PSTEP; ret_nxt = S_PSQR; state_nxt = S_WAIT;
        end else state_nxt = S_PSQR;
      end
      S_PSQR: begin cmd_o.op = OP_SQR; ret_nxt = S_PLOOP; state_nxt = S_WAIT; end
      S_IINIT: begin cmd_o.op = OP_IINIT; state_nxt = S_ISTEP; end
      S_ISTEP: begin
        if (sts_i.t_zero) state_nxt = S_IFIN;
        else begin cmd_o.op = OP_ISTEP; ret_nxt = S_ISTEP; state_nxt = S_WAIT; end
      end
      S_IFIN: begin
        cmd_o.op = OP_IFIN;
        state_nxt = (func_r == FN_DIV) ? S_DMUL : S_DONE;
      end
      S_DMUL: begin
        if (!sts_i.inv_ok) state_nxt = S_DONE;
        else begin cmd_o.op = OP_DMUL; ret_nxt = S_DONE; state_nxt = S_WAIT; end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
    end
    if (state_r == S_IDLE && start) begin
      func_r <= func_i; neg_r <= neg_exp_i;
    end
  end

  assign busy = state_r != S_IDLE;
  assign done_o = state_r == S_DONE;
endmodule
